[src/assert_macros.svh]
// assertion helpers included by the core rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// implication checked on the next clock edge
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[src/q2e_pkg.sv]
// ----------------------------------------------------------------------------
// q2e_pkg
// shared widths, constants and the cordic arctangent table
// ----------------------------------------------------------------------------
package q2e_pkg;

  localparam int CordicSteps = 16;
  localparam int TableLen    = 24;
  localparam int Steps       = (CordicSteps > TableLen) ? TableLen : CordicSteps;

  // product terms are q2.28; cordic vectors grow by about 1.65, plus sign
  localparam int VecW = 36;
  // angle accumulator, 1/256 hundredth of a degree
  localparam int AngW = 24;
  // sqrt operand and root widths
  localparam int SqOpW  = 57;
  localparam int RootW  = 29;

  // sideband carried through the square root pipe: clamp, spare, sr, cr, sy, cy
  localparam int SqSideW = 4 * VecW + 2;
  // sideband carried through each cordic lane
  localparam int CrSideW = 2;

  localparam logic signed [AngW-1:0] HalfTurn = AngW'(18000 * 256);
  localparam logic signed [VecW-1:0] OneQ28   = VecW'(64'sd1 << 28);

  function automatic logic signed [AngW-1:0] atan_entry(input int i);
    logic signed [AngW-1:0] v;
    case (i)
      0:  v = AngW'(1152000);
      1:  v = AngW'(680065);
      2:  v = AngW'(359328);
      3:  v = AngW'(182400);
      4:  v = AngW'(91554);
      5:  v = AngW'(45822);
      6:  v = AngW'(22916);
      7:  v = AngW'(11459);
      8:  v = AngW'(5730);
      9:  v = AngW'(2865);
      10: v = AngW'(1432);
      11: v = AngW'(716);
      12: v = AngW'(358);
      13: v = AngW'(179);
      14: v = AngW'(90);
      15: v = AngW'(45);
      16: v = AngW'(22);
      17: v = AngW'(11);
      18: v = AngW'(6);
      19: v = AngW'(3);
      20: v = AngW'(1);
      21: v = AngW'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

  // one cordic lane item
  typedef struct packed {
    logic signed [VecW-1:0] x;
    logic signed [VecW-1:0] y;
    logic signed [AngW-1:0] z;
  } cvec_t;

endpackage

[src/q2e_cordic.sv]
// ----------------------------------------------------------------------------
// q2e_cordic
// pipelined vectoring cordic, one register stage per iteration, with a
// sideband word carried alongside
// ----------------------------------------------------------------------------
module q2e_cordic
  import q2e_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    adv,
  input  logic                    in_vld,
  input  logic signed [VecW-1:0]  in_x,
  input  logic signed [VecW-1:0]  in_y,
  input  logic [CrSideW-1:0]      in_side,
  output logic                    out_vld,
  output logic signed [AngW-1:0]  out_z,
  output logic [CrSideW-1:0]      out_side
);

  cvec_t              st_r   [Steps+1];
  logic               vld_r  [Steps+1];
  logic               zro_r  [Steps+1];
  logic [CrSideW-1:0] side_r [Steps+1];

  // prerotation into the right half plane
  cvec_t pre;
  always_comb begin
    pre.x = in_x;
    pre.y = in_y;
    pre.z = '0;
    if (in_x < 0) begin
      pre.x = -in_x;
      pre.y = -in_y;
      pre.z = (in_y >= 0) ? HalfTurn : -HalfTurn;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r[0] <= 1'b0;
    else if (adv) vld_r[0] <= in_vld;
    if (adv) begin
      st_r[0]   <= pre;
      zro_r[0]  <= (in_x == '0) && (in_y == '0);
      side_r[0] <= in_side;
    end
  end

  // one micro-rotation per stage
  for (genvar i = 0; i < Steps; i++) begin : g_it
    cvec_t nxt;
    always_comb begin
      if (st_r[i].y >= 0) begin
        nxt.x = st_r[i].x + (st_r[i].y >>> i);
        nxt.y = st_r[i].y - (st_r[i].x >>> i);
        nxt.z = st_r[i].z + atan_entry(i);
      end else begin
        nxt.x = st_r[i].x - (st_r[i].y >>> i);
        nxt.y = st_r[i].y + (st_r[i].x >>> i);
        nxt.z = st_r[i].z - atan_entry(i);
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) vld_r[i+1] <= 1'b0;
      else if (adv) vld_r[i+1] <= vld_r[i];
      if (adv) begin
        st_r[i+1]   <= nxt;
        zro_r[i+1]  <= zro_r[i];
        side_r[i+1] <= side_r[i];
      end
    end
  end

  // a zero vector has angle zero
  assign out_vld  = vld_r[Steps];
  assign out_z    = zro_r[Steps] ? '0 : st_r[Steps].z;
  assign out_side = side_r[Steps];

endmodule

[src/q2e_sqrt.sv]
// ----------------------------------------------------------------------------
// q2e_sqrt
// pipelined restoring integer square root, one result bit per stage
// ----------------------------------------------------------------------------
module q2e_sqrt
  import q2e_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  logic               in_vld,
  input  logic [SqOpW-1:0]   in_op,
  input  logic [SqSideW-1:0] in_side,
  output logic               out_vld,
  output logic [RootW-1:0]   out_root,
  output logic [SqSideW-1:0] out_side
);

  localparam int Bits = RootW;
  localparam int RemW = RootW + 2;

  logic [SqOpW-1:0]   op_r   [Bits+1];
  logic [RemW-1:0]    rem_r  [Bits+1];
  logic [RootW-1:0]   root_r [Bits+1];
  logic               vld_r  [Bits+1];
  logic [SqSideW-1:0] side_r [Bits+1];

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r[0] <= 1'b0;
    else if (adv) vld_r[0] <= in_vld;
    if (adv) begin
      op_r[0]   <= in_op;
      rem_r[0]  <= '0;
      root_r[0] <= '0;
      side_r[0] <= in_side;
    end
  end

  // bring in two operand bits, try root*4+1
  for (genvar k = 0; k < Bits; k++) begin : g_bit
    localparam int Sh = 2 * (Bits - 1 - k);
    logic [RemW-1:0] r2, trial;
    logic [1:0]      pair;
    always_comb begin
      pair  = 2'((({1'b0, op_r[k]}) >> Sh) & 58'd3);
      r2    = {rem_r[k][RemW-3:0], pair};
      trial = {root_r[k], 2'b01};
    end
    always_ff @(posedge clk) begin
      if (!rst_n) vld_r[k+1] <= 1'b0;
      else if (adv) vld_r[k+1] <= vld_r[k];
      if (adv) begin
        op_r[k+1]   <= op_r[k];
        side_r[k+1] <= side_r[k];
        if (r2 >= trial) begin
          rem_r[k+1]  <= r2 - trial;
          root_r[k+1] <= {root_r[k][RootW-2:0], 1'b1};
        end else begin
          rem_r[k+1]  <= r2;
          root_r[k+1] <= {root_r[k][RootW-2:0], 1'b0};
        end
      end
    end
  end

  assign out_vld  = vld_r[Bits];
  assign out_root = root_r[Bits];
  assign out_side = side_r[Bits];

endmodule

[src/quaternion_to_euler_angles_core.sv]
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles_core
// Takes one q1.14 quaternion per cycle while the output register is free, and
// returns zyx roll, pitch and yaw in hundredths of a degree. The whole
// datapath is one pipeline that advances whenever the output register is free,
// so one item enters every cycle while it is free. Data passes through the
// product stages, the input register plus one-bit-per-stage square root for
// the pitch cosine, the cordic stages and the output rounding. Roll and yaw
// are delayed to match the pitch.
// ----------------------------------------------------------------------------
module quaternion_to_euler_angles_core
  import q2e_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] in_quat_w,
  input  logic signed [15:0] in_quat_x,
  input  logic signed [15:0] in_quat_y,
  input  logic signed [15:0] in_quat_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_roll_angle,
  output logic signed [14:0] out_pitch_angle,
  output logic signed [15:0] out_yaw_angle,
  output logic               out_pitch_clamped
);
  `include "assert_macros.svh"

  localparam int SideW = 3 * VecW + 2;

  logic adv;
  // whole pipe moves together when the output stage can take data
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // stage 1: raw products
  logic                   v1_r;
  logic signed [31:0]     wx_r, yz_r, xx_r, yy_r, wz_r, xy_r, zz_r, wy_r, zx_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else if (adv) v1_r <= in_valid;
    if (adv) begin
      wx_r <= in_quat_w * in_quat_x;
      yz_r <= in_quat_y * in_quat_z;
      xx_r <= in_quat_x * in_quat_x;
      yy_r <= in_quat_y * in_quat_y;
      wz_r <= in_quat_w * in_quat_z;
      xy_r <= in_quat_x * in_quat_y;
      zz_r <= in_quat_z * in_quat_z;
      wy_r <= in_quat_w * in_quat_y;
      zx_r <= in_quat_z * in_quat_x;
    end
  end

  // stage 2: q2.28 vector terms and pitch sine
  logic                   v2_r;
  logic signed [VecW-1:0] sr_r, cr_r, sy_r, cy_r, sp_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else if (adv) v2_r <= v1_r;
    if (adv) begin
      sr_r <= (VecW'(wx_r) + VecW'(yz_r)) <<< 1;
      cr_r <= OneQ28 - ((VecW'(xx_r) + VecW'(yy_r)) <<< 1);
      sy_r <= (VecW'(wz_r) + VecW'(xy_r)) <<< 1;
      cy_r <= OneQ28 - ((VecW'(yy_r) + VecW'(zz_r)) <<< 1);
      sp_r <= (VecW'(wy_r) - VecW'(zx_r)) <<< 1;
    end
  end

  // stage 3: square of the sine, clamp detection
  logic                   v3_r, clamp3_r;
  logic [SqOpW-1:0]       sq_op_r;
  logic signed [VecW-1:0] sr3_r, cr3_r, sy3_r, cy3_r, sp3_r;
  logic [29:0]            sp_mag;
  logic [59:0]            sp_sq;
  always_comb begin
    sp_mag = 30'(sp_r < 0 ? -sp_r : sp_r);
    sp_sq  = sp_mag * sp_mag;
  end
  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else if (adv) v3_r <= v2_r;
    if (adv) begin
      clamp3_r <= (sp_r >= OneQ28) || (sp_r <= -OneQ28);
      sq_op_r  <= SqOpW'((61'd1 << 56) - {1'b0, sp_sq});
      sr3_r <= sr_r; cr3_r <= cr_r; sy3_r <= sy_r; cy3_r <= cy_r; sp3_r <= sp_r;
    end
  end

  // pitch cosine through the square root pipe, other terms ride along
  logic                   sq_vld;
  logic [RootW-1:0]       root;
  logic [SideW-1:0]       sq_side;
  logic signed [VecW-1:0] sr4, cr4, sy4, sp4;
  logic                   clamp4;
  logic signed [VecW-1:0] cy4;
  q2e_sqrt u_sqrt (
    .clk, .rst_n, .adv,
    .in_vld   (v3_r),
    .in_op    (clamp3_r ? '0 : sq_op_r),
    .in_side  ({clamp3_r, 1'b0, sr3_r, cr3_r, sy3_r, cy3_r}),
    .out_vld  (sq_vld),
    .out_root (root),
    .out_side ({sq_side, cy4})
  );
  assign {clamp4, sr4, cr4, sy4} = {sq_side[SideW-1], sq_side[3*VecW-1:0]};
  // sp bypasses the sideband and rides a separate delay line matched to the root pipe
  logic signed [VecW-1:0] sp_d_r [RootW+1];
  always_ff @(posedge clk) begin
    if (adv) sp_d_r[0] <= sp3_r;
  end
  for (genvar k = 0; k < RootW; k++) begin : g_spd
    always_ff @(posedge clk) begin
      if (adv) sp_d_r[k+1] <= sp_d_r[k];
    end
  end
  assign sp4 = sp_d_r[RootW];

  // three cordic lanes in lockstep
  logic                   r_vld, p_vld, y_vld;
  logic signed [AngW-1:0] r_z, p_z, y_z;
  logic [CrSideW-1:0]     p_side, r_side, y_side;
  q2e_cordic u_roll (
    .clk, .rst_n, .adv, .in_vld(sq_vld), .in_x(cr4), .in_y(sr4),
    .in_side(2'b00), .out_vld(r_vld), .out_z(r_z), .out_side(r_side)
  );
  q2e_cordic u_pitch (
    .clk, .rst_n, .adv, .in_vld(sq_vld), .in_x(VecW'({1'b0, root})), .in_y(sp4),
    .in_side({clamp4, sp4 > 0}), .out_vld(p_vld), .out_z(p_z), .out_side(p_side)
  );
  q2e_cordic u_yaw (
    .clk, .rst_n, .adv, .in_vld(sq_vld), .in_x(cy4), .in_y(sy4),
    .in_side(2'b00), .out_vld(y_vld), .out_z(y_z), .out_side(y_side)
  );

  // rounding and saturation
  function automatic logic signed [15:0] to_cdeg(input logic signed [AngW-1:0] z,
                                                 input int lim);
    logic signed [AngW-1:0] r;
    r = (z + AngW'(128)) >>> 8;
    if (r > AngW'(lim)) r = AngW'(lim);
    if (r < -AngW'(lim)) r = -AngW'(lim);
    return 16'(r);
  endfunction

  logic signed [15:0] pitch_c;
  always_comb begin
    if (p_side[1]) pitch_c = p_side[0] ? 16'sd9000 : -16'sd9000;
    else           pitch_c = to_cdeg(p_z, 9000);
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else if (adv) out_valid <= p_vld;
    if (adv) begin
      out_roll_angle    <= to_cdeg(r_z, 18000);
      out_yaw_angle     <= to_cdeg(y_z, 18000);
      out_pitch_angle   <= 15'(pitch_c);
      out_pitch_clamped <= p_side[1] | (r_side[1] & y_side[1]);
    end
  end

  `ASSERT_ALWAYS(a_lanes_aligned, clk, rst_n, (r_vld == p_vld) && (y_vld == p_vld))
  `ASSERT_NEXT(a_stall_holds, clk, rst_n, out_valid && !out_ready,
               out_valid && $stable(out_roll_angle) && $stable(out_pitch_angle))
  `ASSERT_ALWAYS(a_pitch_range, clk, rst_n,
                 !out_valid || (out_pitch_angle <= 15'sd9000 && out_pitch_angle >= -15'sd9000))

endmodule
